// File: hw/rtl/zigzag_scan_reorder_core_defines.svh
// ----------------------------------------------------------------------------
// Zigzag scan reorder assertion macros
// Shared concurrent assertion forms for the zigzag scan reorder RTL.
// ----------------------------------------------------------------------------
`ifndef ZIGZAG_SCAN_REORDER_CORE_DEFINES_SVH
`define ZIGZAG_SCAN_REORDER_CORE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define ZSR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ZSR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/zsr_pkg.sv
// ----------------------------------------------------------------------------
// Zigzag scan reorder package
// Types and fixed constants shared by the zigzag scan reorder modules.
// ----------------------------------------------------------------------------
package zsr_pkg;

    localparam int SIDE_W = 4;
    localparam int ELEM_W = 32;

    typedef logic [SIDE_W-1:0] t_side;
    typedef logic [ELEM_W-1:0] t_elem;

    localparam t_side SIDE_RESET = 4'd8;

    // Control from the top level to the zigzag walker.
    typedef struct packed {
        logic start;
        logic step;
    } t_walk_ctl;

    // Status from the zigzag walker.
    typedef struct packed {
        logic busy;
        logic last;
    } t_walk_sts;

endpackage

// File: hw/rtl/zsr_walker.sv
// ----------------------------------------------------------------------------
// Zigzag walker
// Steps a row/column position along the zigzag diagonal order and forms
// the row-major buffer address of the current position.
// ----------------------------------------------------------------------------
module zsr_walker #(
    parameter int MAX_SIDE = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  zsr_pkg::t_side          i_side,
    input  zsr_pkg::t_walk_ctl      i_ctl,
    output zsr_pkg::t_walk_sts      o_sts,
    output logic [((MAX_SIDE*MAX_SIDE > 1) ? $clog2(MAX_SIDE*MAX_SIDE) : 1)-1:0] o_addr
);

    localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RC_W   = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

    logic            r_busy, n_busy;
    logic            r_up, n_up;
    logic [RC_W-1:0] r_row, n_row;
    logic [RC_W-1:0] r_col, n_col;
    logic [RC_W-1:0] lim;
    logic            at_last;

    assign lim     = RC_W'(i_side - zsr_pkg::t_side'(1));
    assign at_last = (r_row == lim) && (r_col == lim);

    always_comb begin
        n_busy = r_busy;
        n_up   = r_up;
        n_row  = r_row;
        n_col  = r_col;
        if (i_ctl.start) begin
            n_busy = 1'b1;
            n_up   = 1'b1;
            n_row  = '0;
            n_col  = '0;
        end else if (i_ctl.step && r_busy) begin
            if (at_last) begin
                n_busy = 1'b0;
            end else if (r_up) begin
                // Moving up-right; turn at the right edge or the top edge.
                if (r_col == lim) begin
                    n_row = r_row + RC_W'(1);
                    n_up  = 1'b0;
                end else if (r_row == '0) begin
                    n_col = r_col + RC_W'(1);
                    n_up  = 1'b0;
                end else begin
                    n_row = r_row - RC_W'(1);
                    n_col = r_col + RC_W'(1);
                end
            end else begin
                // Moving down-left; turn at the bottom edge or the left edge.
                if (r_row == lim) begin
                    n_col = r_col + RC_W'(1);
                    n_up  = 1'b1;
                end else if (r_col == '0) begin
                    n_row = r_row + RC_W'(1);
                    n_up  = 1'b1;
                end else begin
                    n_row = r_row + RC_W'(1);
                    n_col = r_col - RC_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_up   <= 1'b1;
            r_row  <= '0;
            r_col  <= '0;
        end else begin
            r_busy <= n_busy;
            r_up   <= n_up;
            r_row  <= n_row;
            r_col  <= n_col;
        end
    end

    // The product stays below the buffer depth, so truncation is exact.
    assign o_addr = ADDR_W'(ADDR_W'(r_row) * ADDR_W'(i_side)) + ADDR_W'(r_col);

    assign o_sts.busy = r_busy;
    assign o_sts.last = at_last;

endmodule

// File: hw/rtl/zigzag_scan_reorder_core.sv
// ----------------------------------------------------------------------------
// Zigzag scan reorder core
// Buffers a square matrix given in row-major order and plays it back in
// zigzag diagonal order.
// ----------------------------------------------------------------------------
// Usage:
// Input channel (i_valid, i_element, o_stall) takes one matrix element per
// request in row-major order, one per cycle while loading. A request is taken
// when i_valid is high and o_stall is low.
// Output channel (o_valid, o_element_out, o_last_of_run, i_stall) gives the
// side*side elements in zigzag order once the element that completes the
// matrix is taken; o_last_of_run marks the final one.
// Configuration channel (i_cfg_valid, o_cfg_ready, i_cfg_matrix_side) sets
// the matrix side; 0 acts as 1 and values above MAX_SIDE act as MAX_SIDE.
// o_valid rises after the completing element starts the walker and the first
// read moves through the read register into the output register. Playback
// then gives one result per cycle while i_stall is low, set by the single
// read port of the element buffer.
// o_stall is high while the buffer is being read out. A stall on the output
// holds the result register and pauses the reads without losing data.
// Reset clears the load count and sets the side to 8; buffer contents are
// not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`include "zigzag_scan_reorder_core_defines.svh"

module zigzag_scan_reorder_core #(
    parameter int MAX_SIDE = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic signed [31:0]    i_element,
    output logic                  o_stall,
    output logic                  o_valid,
    output logic signed [31:0]    o_element_out,
    output logic                  o_last_of_run,
    input  logic                  i_stall,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [3:0]            i_cfg_matrix_side
);

    localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    zsr_pkg::t_elem      mem [DEPTH];

    zsr_pkg::t_side      r_side;
    zsr_pkg::t_side      eff_side;
    logic [CNT_W-1:0]    r_count, n_count, total;
    logic                in_acc;
    logic                done_load;

    zsr_pkg::t_walk_ctl  walk_ctl;
    zsr_pkg::t_walk_sts  walk_sts;
    logic [ADDR_W-1:0]   rd_addr;

    logic                issue;
    logic                move;
    logic                r_rd_vld;
    logic                r_rd_last;
    zsr_pkg::t_elem      r_rd_data;
    zsr_pkg::t_elem      r_out_data;
    logic                r_out_vld;
    logic                r_out_last;

    // Configuration register, always ready.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= zsr_pkg::SIDE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_side <= i_cfg_matrix_side;
        end
    end

    always_comb begin
        eff_side = r_side;
        if (r_side == '0) begin
            eff_side = zsr_pkg::t_side'(1);
        end else if (r_side > zsr_pkg::t_side'(MAX_SIDE)) begin
            eff_side = zsr_pkg::t_side'(MAX_SIDE);
        end
    end

    assign total = CNT_W'(CNT_W'(eff_side) * CNT_W'(eff_side));

    // Load side.
    assign o_stall   = walk_sts.busy;
    assign in_acc    = i_valid && !o_stall;
    assign n_count   = r_count + CNT_W'(1);
    assign done_load = in_acc && (n_count >= total);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (in_acc) begin
            r_count <= done_load ? '0 : n_count;
        end
    end

    // Playback: reads are issued only while the walk is busy and the read stage is empty or frees up this cycle.
    assign move  = r_rd_vld && (!r_out_vld || !i_stall);
    assign issue = walk_sts.busy && (!r_rd_vld || move);

    assign walk_ctl.start = done_load;
    assign walk_ctl.step  = issue;

    zsr_walker #(
        .MAX_SIDE (MAX_SIDE)
    ) u_walker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_side  (eff_side),
        .i_ctl   (walk_ctl),
        .o_sts   (walk_sts),
        .o_addr  (rd_addr)
    );

    // Element buffer: one write port for loading, one registered read port.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            mem[r_count[ADDR_W-1:0]] <= i_element;
        end
        if (issue) begin
            r_rd_data <= mem[rd_addr];
            r_rd_last <= walk_sts.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_rd_vld <= issue || (r_rd_vld && !move);
            if (move) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out_data <= r_rd_data;
            r_out_last <= r_rd_last;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_element_out = r_out_data;
    assign o_last_of_run = r_out_last;

    `ZSR_ASSERT_NEXT(a_rd_hold, r_rd_vld && !move, r_rd_vld && $stable(r_rd_data), "read lost")
    `ZSR_ASSERT_NEXT(a_last_ends_walk, issue && walk_sts.last, !walk_sts.busy, "walk overran")
    `ZSR_ASSERT_SAME(a_count_range, 1'b1, r_count < CNT_W'(DEPTH), "load count out of range")

endmodule
